@@ hdl/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants and types for the set-1 scan code translator.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned EntryW     = 16;
  localparam int unsigned PauseSkip  = 2;
  localparam int unsigned SkipW      = 2;

  localparam logic [7:0] PauseCodeReset = 8'd153;

  localparam logic [7:0] ScanExt   = 8'hE0;
  localparam logic [7:0] ScanPause = 8'hE1;

  localparam logic [6:0] IdxLShift     = 7'd42;
  localparam logic [6:0] IdxRShift     = 7'd54;
  localparam logic [6:0] IdxCaps       = 7'd58;
  localparam logic [6:0] IdxNum        = 7'd69;
  localparam logic [6:0] IdxScroll     = 7'd70;
  localparam logic [6:0] IdxShiftFirst = 7'd2;
  localparam logic [6:0] IdxShiftLast  = 7'd53;
  localparam logic [6:0] IdxPadFirst   = 7'd71;
  localparam logic [6:0] IdxPadLast    = 7'd83;

  localparam logic [7:0] LetterFirst = 8'h61;
  localparam logic [7:0] LetterLast  = 8'h7A;

  typedef enum logic [0:0] {
    ACT_XLATE = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

endpackage

@@ hdl/sca_ram.sv @@
// ----------------------------------------------------------------------------
// sca_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
module sca_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/scan_code_to_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// scan_code_to_ascii_unit
// Set-1 scan byte to key code translator with shift and lock tracking.
// Stages: stage-1 register with the table read, then the output register.
// Throughput: one request per cycle when not stalled, set by the single table
// read port. Reset clears all flags, the skip count and both stage valid bits;
// pause_code resets to 153. The table is undefined until written.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_unit (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] scan_byte_i,
  input  logic [6:0] entry_index_i,
  input  logic [7:0] plain_code_i,
  input  logic [7:0] shifted_code_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       key_valid_o,
  output logic [7:0] key_code_o,
  output logic       key_down_o,
  output logic       key_extended_o,
  output logic       led_update_o,
  output logic       caps_led_o,
  output logic       num_led_o,
  output logic       scroll_led_o
);

  localparam int unsigned SkipW = sca_pkg::SkipW;
  localparam logic [SkipW-1:0] SkipLoad = SkipW'(sca_pkg::PauseSkip);

  typedef struct packed {
    logic       is_pause;
    logic       oob;
    logic       comb_letter;
    logic       comb_other;
    logic       down;
    logic       ext;
    logic       led;
    logic       caps;
    logic       num;
    logic       scroll;
  } s1_t;

  typedef struct packed {
    logic [7:0] code;
    logic       down;
    logic       ext;
    logic       led;
    logic       caps;
    logic       num;
    logic       scroll;
  } res_t;

  logic [7:0]            pause_code_q;
  logic                  shift_q, shift_d;
  logic                  caps_q, caps_d;
  logic                  num_q, num_d;
  logic                  scroll_q, scroll_d;
  logic                  prefix_q, prefix_d;
  logic [SkipW-1:0]      skip_q, skip_d;

  logic                  s1_valid_q, s1_valid_d;
  s1_t                   s1_q, s1_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_q, res_d;

  logic                  acc, xlate, skipping, is_e0, is_e1, normal, produce;
  logic                  down, led, oob, s1_adv, wr_en;
  logic [6:0]            idx;
  logic [sca_pkg::EntryW-1:0] rdata, entry;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign acc        = in_valid_i && in_ready_o;
  assign xlate      = acc && (sca_pkg::action_e'(action_i) == sca_pkg::ACT_XLATE);
  assign wr_en      = acc && (sca_pkg::action_e'(action_i) == sca_pkg::ACT_WRITE)
                      && ({1'b0, entry_index_i} < 8'(sca_pkg::TableDepth));
  assign idx        = scan_byte_i[6:0];
  assign skipping   = skip_q != '0;
  assign is_e0      = scan_byte_i == sca_pkg::ScanExt;
  assign is_e1      = scan_byte_i == sca_pkg::ScanPause;
  assign normal     = xlate && !skipping && !is_e0 && !is_e1;
  assign produce    = xlate && !skipping && !is_e0;
  assign down       = !scan_byte_i[7];
  assign oob        = {1'b0, idx} >= 8'(sca_pkg::TableDepth);

  always_comb begin
    shift_d  = shift_q;
    caps_d   = caps_q;
    num_d    = num_q;
    scroll_d = scroll_q;
    prefix_d = prefix_q;
    skip_d   = skip_q;
    led      = 1'b0;
    if (xlate) begin
      if (skipping) begin
        skip_d = skip_q - SkipW'(1);
      end else if (is_e1) begin
        skip_d = SkipLoad;
      end else if (is_e0) begin
        prefix_d = 1'b1;
      end else begin
        prefix_d = 1'b0;
        if (idx == sca_pkg::IdxLShift || idx == sca_pkg::IdxRShift) begin
          shift_d = down;
        end else if (down && idx == sca_pkg::IdxCaps) begin
          caps_d = !caps_q;
          led    = 1'b1;
        end else if (down && idx == sca_pkg::IdxNum) begin
          num_d = !num_q;
          led   = 1'b1;
        end else if (down && idx == sca_pkg::IdxScroll) begin
          scroll_d = !scroll_q;
          led      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    s1_d.is_pause    = is_e1;
    s1_d.oob         = oob;
    s1_d.comb_letter = shift_q ^ caps_q;
    if (idx >= sca_pkg::IdxShiftFirst && idx <= sca_pkg::IdxShiftLast) begin
      s1_d.comb_other = shift_q;
    end else if (idx >= sca_pkg::IdxPadFirst && idx <= sca_pkg::IdxPadLast && !prefix_q) begin
      s1_d.comb_other = num_q;
    end else begin
      s1_d.comb_other = 1'b0;
    end
    s1_d.down   = is_e1 ? 1'b1 : down;
    s1_d.ext    = is_e1 ? 1'b0 : prefix_q;
    s1_d.led    = led;
    s1_d.caps   = caps_d;
    s1_d.num    = num_d;
    s1_d.scroll = scroll_d;
  end

  sca_ram #(
    .Width (sca_pkg::EntryW),
    .Depth (sca_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (entry_index_i[sca_pkg::AddrW-1:0]),
    .wdata_i ({shifted_code_i, plain_code_i}),
    .re_i    (normal),
    .raddr_i (idx[sca_pkg::AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    entry = s1_q.oob ? '0 : rdata;
    if (s1_q.is_pause) begin
      res_d.code = pause_code_q;
    end else if (entry[7:0] >= sca_pkg::LetterFirst && entry[7:0] <= sca_pkg::LetterLast) begin
      res_d.code = s1_q.comb_letter ? entry[15:8] : entry[7:0];
    end else begin
      res_d.code = s1_q.comb_other ? entry[15:8] : entry[7:0];
    end
    res_d.down   = s1_q.down;
    res_d.ext    = s1_q.ext;
    res_d.led    = s1_q.led;
    res_d.caps   = s1_q.caps;
    res_d.num    = s1_q.num;
    res_d.scroll = s1_q.scroll;
  end

  always_comb begin
    if (acc) begin
      s1_valid_d = produce;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_code_q <= sca_pkg::PauseCodeReset;
      shift_q      <= 1'b0;
      caps_q       <= 1'b0;
      num_q        <= 1'b0;
      scroll_q     <= 1'b0;
      prefix_q     <= 1'b0;
      skip_q       <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pause_code_q <= cfg_wdata_i;
      end
      shift_q     <= shift_d;
      caps_q      <= caps_d;
      num_q       <= num_d;
      scroll_q    <= scroll_d;
      prefix_q    <= prefix_d;
      skip_q      <= skip_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_valid_o    = 1'b1;
  assign key_code_o     = out_q.code;
  assign key_down_o     = out_q.down;
  assign key_extended_o = out_q.ext;
  assign led_update_o   = out_q.led;
  assign caps_led_o     = out_q.caps;
  assign num_led_o      = out_q.num;
  assign scroll_led_o   = out_q.scroll;

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_skip_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= SkipLoad)
    else $error("skip count above pause length");

  a_led_on_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.led |-> out_q.down)
    else $error("led update on a release");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q && out_valid_q)
    else $error("request lost during output stall");
`endif

endmodule
